@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros: shared concurrent assertion macros
// clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

`endif

@@ sv/bmfm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmfm_pkg: shared types and sizes of the string search block
// store depths, index widths and the bad-character table write group
// ----------------------------------------------------------------------------
package bmfm_pkg;

  localparam int unsigned PatternMax = 64;
  localparam int unsigned TextMax    = 4096;

  localparam int unsigned PA_W = $clog2(PatternMax);     // pattern address
  localparam int unsigned PL_W = $clog2(PatternMax + 1); // pattern length
  localparam int unsigned TA_W = $clog2(TextMax);        // text address
  localparam int unsigned TL_W = $clog2(TextMax + 1);    // text length
  localparam int unsigned BC_W = PL_W;                   // last index + 1

  typedef struct packed {
    logic            clr;
    logic            en;
    logic [7:0]      addr;
    logic [BC_W-1:0] data;
  } bc_wr_t;

endpackage

@@ sv/bmfm_bctab.sv @@
// ----------------------------------------------------------------------------
// bmfm_bctab: bad-character table
// 256-entry memory with per-entry valid bits; an entry not valid reads zero
// ----------------------------------------------------------------------------
module bmfm_bctab (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmfm_pkg::bc_wr_t      wr_i,
  input  logic [7:0]            rd_addr_i,
  output logic [bmfm_pkg::BC_W-1:0] rd_data_o
);
  import bmfm_pkg::*;

  logic [BC_W-1:0] mem [256];
  logic [255:0]    vld_q;
  logic [BC_W-1:0] data_q;
  logic            hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_i.clr) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      hit_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = hit_q ? data_q : '0;

endmodule

@@ sv/boyer_moore_first_match_top.sv @@
// ----------------------------------------------------------------------------
// boyer_moore_first_match_top: first-occurrence string search
// loads a pattern and a text into memories, then searches right to left
// ----------------------------------------------------------------------------
// Pattern and text bytes are taken one beat per cycle. A beat with tuser = 0
// is a pattern byte, tuser = 1 a text byte, tlast ends the pattern or the
// text. The last text byte starts the search: the bad-character table is
// built first (one pattern memory read per cycle), then each alignment is
// compared right to left, each compared byte taking a synchronous read of
// pattern and text memories (S_RD) and then a compare (S_CMP); a mismatch
// adds S_SH for the bad-character table lookup that sets the shift. One
// result beat leaves per search with the leftmost match position; an
// oversized pattern or text reports overflow instead. No input is taken
// while a search runs or while a result beat waits on the master side.
// ----------------------------------------------------------------------------
module boyer_moore_first_match_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tuser,   // kind: 0 pattern, 1 text
  input  logic        s_axis_tlast,   // final_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] found, [12:1] match_start,
                                      // [13] overflow_error, [15:14] zero
);
  import bmfm_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,   // taking beats
    S_BUILD,  // filling the bad-character table
    S_RD,     // memory reads for one compare
    S_CMP,    // compare pattern and text bytes
    S_SH      // bad-character lookup ready, shift
  } state_e;

  state_e state_q;

  // storage
  logic [7:0] pmem [PatternMax];
  logic [7:0] tmem [TextMax];
  logic [7:0] p_rd_q, t_rd_q;

  // load bookkeeping
  logic [PL_W-1:0] plen_q;
  logic [TL_W-1:0] tlen_q;
  logic            ploading_q, pov_q, tov_q;

  // search registers
  logic [PL_W-1:0] b_q;        // build read index
  logic            bw_q;       // build write pending
  logic [BC_W-1:0] bdat_q;
  logic [PA_W-1:0] i_q;        // compare index in pattern
  logic [TL_W-1:0] s_q;        // alignment
  logic [TL_W-1:0] lim_q;      // last alignment n-m

  // result register
  logic            out_vld_q, out_found_q, out_err_q;
  logic [11:0]     out_pos_q;

  logic            in_acc;
  logic [PA_W-1:0] p_addr;
  logic [TL_W-1:0] t_sum;
  logic [PL_W-1:0] pw_idx;
  logic            p_we, t_we;
  bc_wr_t          bc_wr;
  logic [BC_W-1:0] bc_rd;
  logic [PL_W-1:0] ip1, sh;
  logic [TL_W:0]   s_next;

  assign s_axis_tready = (state_q == S_LOAD) && !out_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // pattern write slot: a pattern byte outside pattern loading restarts it
  assign pw_idx = ploading_q ? plen_q : '0;
  assign p_we   = in_acc && !s_axis_tuser && (pw_idx < PL_W'(PatternMax));
  assign t_we   = in_acc && s_axis_tuser && (tlen_q < TL_W'(TextMax));

  assign p_addr = (state_q == S_BUILD) ? b_q[PA_W-1:0] : i_q;
  assign t_sum  = s_q + TL_W'(i_q);

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[pw_idx[PA_W-1:0]] <= s_axis_tdata;
    end
    if (t_we) begin
      tmem[tlen_q[TA_W-1:0]] <= s_axis_tdata;
    end
    p_rd_q <= pmem[p_addr];
    t_rd_q <= tmem[t_sum[TA_W-1:0]];
  end

  // table written from the build pipe, cleared on every last text byte taken
  always_comb begin
    bc_wr.clr  = in_acc && s_axis_tuser && s_axis_tlast;
    bc_wr.en   = bw_q;
    bc_wr.addr = p_rd_q;
    bc_wr.data = bdat_q;
  end

  bmfm_bctab u_bctab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (bc_wr),
    .rd_addr_i (t_rd_q),
    .rd_data_o (bc_rd)
  );

  // bad-character shift, at least one
  assign ip1    = PL_W'(i_q) + PL_W'(1);
  assign sh     = (bc_rd >= ip1) ? PL_W'(1) : (ip1 - bc_rd);
  assign s_next = {1'b0, s_q} + (TL_W + 1)'(sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [TL_W-1:0] n;
    logic            err;
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      plen_q      <= '0;
      tlen_q      <= '0;
      ploading_q  <= 1'b0;
      pov_q       <= 1'b0;
      tov_q       <= 1'b0;
      b_q         <= '0;
      bw_q        <= 1'b0;
      bdat_q      <= '0;
      i_q         <= '0;
      s_q         <= '0;
      lim_q       <= '0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_err_q   <= 1'b0;
      out_pos_q   <= '0;
    end else begin
      bw_q <= 1'b0;
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc && !s_axis_tuser) begin
            if (!ploading_q) begin
              tlen_q <= '0;
              tov_q  <= 1'b0;
              pov_q  <= 1'b0;
            end
            if (p_we) begin
              plen_q <= pw_idx + PL_W'(1);
            end else begin
              plen_q <= pw_idx;
              pov_q  <= 1'b1;
            end
            ploading_q <= !s_axis_tlast;
          end else if (in_acc) begin
            ploading_q <= 1'b0;
            n   = t_we ? (tlen_q + TL_W'(1)) : tlen_q;
            err = pov_q || tov_q || !t_we;
            if (s_axis_tlast) begin
              // text is cleared after every search, the pattern is kept
              tlen_q <= '0;
              tov_q  <= 1'b0;
              if (err || (plen_q == '0) || (TL_W'(plen_q) > n)) begin
                out_vld_q   <= 1'b1;
                out_found_q <= 1'b0;
                out_pos_q   <= '0;
                out_err_q   <= err;
              end else begin
                lim_q   <= n - TL_W'(plen_q);
                b_q     <= '0;
                state_q <= S_BUILD;
              end
            end else if (t_we) begin
              tlen_q <= n;
            end else begin
              tov_q <= 1'b1;
            end
          end
        end
        S_BUILD: begin
          if (b_q < (plen_q - PL_W'(1))) begin
            bw_q   <= 1'b1;
            bdat_q <= b_q + PL_W'(1);
            b_q    <= b_q + PL_W'(1);
          end else begin
            s_q     <= '0;
            i_q     <= PA_W'(plen_q - PL_W'(1));
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (p_rd_q == t_rd_q) begin
            if (i_q == '0) begin
              out_vld_q   <= 1'b1;
              out_found_q <= 1'b1;
              out_pos_q   <= s_q[11:0];
              out_err_q   <= 1'b0;
              state_q     <= S_LOAD;
            end else begin
              i_q     <= i_q - PA_W'(1);
              state_q <= S_RD;
            end
          end else begin
            state_q <= S_SH;
          end
        end
        S_SH: begin
          if (s_next > {1'b0, lim_q}) begin
            out_vld_q   <= 1'b1;
            out_found_q <= 1'b0;
            out_pos_q   <= '0;
            out_err_q   <= 1'b0;
            state_q     <= S_LOAD;
          end else begin
            s_q     <= s_next[TL_W-1:0];
            i_q     <= PA_W'(plen_q - PL_W'(1));
            state_q <= S_RD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_err_q, out_pos_q, out_found_q};

endmodule

@@ sv/bmfm_checker.sv @@
// ----------------------------------------------------------------------------
// bmfm_checker: port-level checks of the string search block
// watches the stream ports over time, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmfm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic        out_wait;
  logic        res_found, res_err;
  logic [11:0] res_pos;
  logic [1:0]  res_pad;

  assign out_wait  = m_axis_tvalid && !m_axis_tready;
  assign res_found = m_axis_tdata[0];
  assign res_pos   = m_axis_tdata[12:1];
  assign res_err   = m_axis_tdata[13];
  assign res_pad   = m_axis_tdata[15:14];

  // result beat holds until taken
  `ASSERT_IMPL(a_out_hold, out_wait, ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
  // no byte taken while a result waits
  `ASSERT_IMPL(a_no_in_while_out, m_axis_tvalid, !s_axis_tready)
  // a match is never reported together with overflow
  `ASSERT_IMPL(a_found_no_err, m_axis_tvalid, !(res_found && res_err))
  // padding bits stay zero, position zero without a match
  `ASSERT_IMPL(a_pad_zero, m_axis_tvalid, (res_pad == 2'b00) && (res_found || (res_pos == 12'd0)))

endmodule

bind boyer_moore_first_match_top bmfm_checker u_bmfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tb_boyer_moore_first_match_top.sv @@
// ----------------------------------------------------------------------------
// tb_boyer_moore_first_match_top: self-checking bench of the string search
// streams patterns and texts in, predicts the leftmost match of every search
// and compares each result beat field by field under random idling and stalls
// ----------------------------------------------------------------------------

// keeps a shadow of pattern and text, expected results wait in a queue
class match_scoreboard;
  typedef struct {
    bit        found;
    bit [11:0] start;
    bit        ovf;
  } match_res_t;

  bit [7:0]   pat_mem [64];
  bit [7:0]   txt_mem [4096];
  int         pat_len, txt_len, phase;
  bit         pat_ovf, txt_ovf;
  match_res_t pending_q[$];
  int         n_errors, n_results, n_hits, n_ovf;

  function new();
    pat_len = 0; txt_len = 0; phase = 0;
    pat_ovf = 0; txt_ovf = 0;
    n_errors = 0; n_results = 0; n_hits = 0; n_ovf = 0;
  endfunction

  // leftmost occurrence of the pattern, or -1
  function int leftmost_match();
    int  s, k;
    bit  ok;
    if (pat_len == 0 || pat_len > txt_len) return -1;
    for (s = 0; s <= txt_len - pat_len; s++) begin
      ok = 1;
      for (k = 0; k < pat_len; k++)
        if (pat_mem[k] != txt_mem[s + k]) begin
          ok = 0;
          break;
        end
      if (ok) return s;
    end
    return -1;
  endfunction

  function void note_beat(bit is_text, bit [7:0] sym, bit last);
    match_res_t r;
    int         pos;
    if (!is_text) begin
      if (phase != 1) begin
        pat_len = 0; txt_len = 0; pat_ovf = 0; txt_ovf = 0; phase = 1;
      end
      if (pat_len < 64) pat_mem[pat_len++] = sym;
      else pat_ovf = 1;
      if (last) phase = 2;
      return;
    end
    phase = 2;
    if (txt_len < 4096) txt_mem[txt_len++] = sym;
    else txt_ovf = 1;
    if (!last) return;
    r.ovf   = pat_ovf | txt_ovf;
    pos     = r.ovf ? -1 : leftmost_match();
    r.found = (pos >= 0);
    r.start = r.found ? pos[11:0] : 12'd0;
    pending_q.push_back(r);
    txt_len = 0;
    txt_ovf = 0;
  endfunction

  function void check_result(bit found, bit [11:0] start, bit ovf);
    match_res_t e;
    if (pending_q.size() == 0) begin
      $error("result beat with no search pending");
      n_errors++;
      return;
    end
    e = pending_q.pop_front();
    n_results++;
    if (e.found) n_hits++;
    if (e.ovf) n_ovf++;
    if (found != e.found) begin
      $error("found: expected %0d actual %0d", e.found, found);
      n_errors++;
    end
    if (start != e.start) begin
      $error("match_start: expected %0d actual %0d", e.start, start);
      n_errors++;
    end
    if (ovf != e.ovf) begin
      $error("overflow_error: expected %0d actual %0d", e.ovf, ovf);
      n_errors++;
    end
  endfunction
endclass

module tb_boyer_moore_first_match_top;
  import bmfm_pkg::*;

  localparam int CycleLimit = 20000000;
  localparam int TailWait   = 200;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser, s_axis_tlast;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;

  match_scoreboard search_sb;
  int          send_idle_pct, recv_stall_pct;
  int          cycle_cnt, beats_sent;
  bit [7:0]    pat_buf[$];

  boyer_moore_first_match_top dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_boyer_moore_first_match_top NOT OK");
      $finish;
    end
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beat: [0] found, [12:1] match_start, [13] overflow_error
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      search_sb.check_result(m_axis_tdata[0], m_axis_tdata[12:1], m_axis_tdata[13]);
  end

  // one input beat; valid only drops for an idle gap before the beat
  task automatic send_beat(bit is_text, bit [7:0] sym, bit last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= is_text;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    search_sb.note_beat(is_text, sym, last);
    beats_sent++;
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold off until every expected result has come back
  task automatic wait_drained();
    pause_sender();
    while (search_sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pattern(int len, int alpha, bit close);
    bit [7:0] b;
    pat_buf.delete();
    for (int k = 0; k < len; k++) begin
      b = (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1) + 8'h61);
      pat_buf.push_back(b);
      send_beat(1'b0, b, close && (k == len - 1));
    end
  endtask

  // random text, often with the last pattern planted somewhere inside
  task automatic send_text(int len, int alpha, bit plant);
    bit [7:0] t[$];
    int       at;
    for (int k = 0; k < len; k++)
      t.push_back((alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1) + 8'h61));
    if (plant && pat_buf.size() > 0 && pat_buf.size() <= len) begin
      at = $urandom_range(len - pat_buf.size());
      foreach (pat_buf[k]) t[at + k] = pat_buf[k];
    end
    foreach (t[k]) send_beat(1'b1, t[k], k == len - 1);
  endtask

  initial begin
    int alpha, plen, tlen, pick;
    search_sb      = new();
    cycle_cnt      = 0;
    beats_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // text with no pattern ever loaded: empty pattern
    send_beat(1'b1, 8'h41, 1'b1);
    // extreme bytes, match at index 1
    send_beat(1'b0, 8'h00, 1'b0);
    send_beat(1'b0, 8'hFF, 1'b1);
    send_beat(1'b1, 8'h11, 1'b0);
    send_beat(1'b1, 8'h00, 1'b0);
    send_beat(1'b1, 8'hFF, 1'b1);
    // same pattern kept for the next text, no hit
    send_beat(1'b1, 8'hFF, 1'b0);
    send_beat(1'b1, 8'h00, 1'b1);
    // text beat ends an unterminated pattern
    send_beat(1'b0, 8'h80, 1'b0);
    send_beat(1'b1, 8'h80, 1'b1);
    // pattern longer than the text
    send_beat(1'b0, 8'h61, 1'b0);
    send_beat(1'b0, 8'h62, 1'b1);
    send_beat(1'b1, 8'h61, 1'b1);
    // repeated-byte pattern exercises the bad-character shift
    send_beat(1'b0, 8'h61, 1'b0);
    send_beat(1'b0, 8'h61, 1'b1);
    send_beat(1'b1, 8'h62, 1'b0);
    send_beat(1'b1, 8'h61, 1'b0);
    send_beat(1'b1, 8'h61, 1'b1);
    wait_drained();

    // pattern store overflow: 65 pattern bytes
    send_pattern(65, 256, 1'b1);
    send_text(8, 256, 1'b0);
    // a fresh pattern clears the overflow, then is reused
    send_pattern(3, 2, 1'b1);
    send_text(40, 2, 1'b1);
    send_text(20, 2, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      while (beats_sent < 150 + 275 * (ph + 1)) begin
        pick  = $urandom_range(99);
        alpha = ($urandom_range(3) == 0) ? 256 : $urandom_range(4, 2);
        plen  = ($urandom_range(15) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        tlen  = $urandom_range(48, 1);
        if (pick < 60) begin
          send_pattern(plen, alpha, 1'b1);
          send_text(tlen, alpha, $urandom_range(1));
        end else if (pick < 80) begin
          // reuse the loaded pattern
          send_text(tlen, alpha, $urandom_range(1));
        end else if (pick < 90) begin
          // pattern cut short by text
          send_pattern(plen, alpha, 1'b0);
          send_text(tlen, alpha, 1'b1);
        end else begin
          // noise: lone beats of any kind
          send_beat($urandom_range(1), 8'($urandom), $urandom_range(1));
        end
      end
      wait_drained();
    end

    while (search_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    $display("covered %0d input beats and %0d searches", beats_sent, search_sb.n_results);
    $display("of which %0d matched and %0d reported store overflow",
             search_sb.n_hits, search_sb.n_ovf);
    if (search_sb.n_errors == 0 && search_sb.pending_q.size() == 0)
      $display("tb_boyer_moore_first_match_top OK");
    else
      $display("tb_boyer_moore_first_match_top NOT OK");
    $finish;
  end
endmodule
